[hw/rtl/lcs_pkg.sv]
// Shared types and constants of the row-wise longest-common-subsequence block.
package lcs_pkg;

   localparam int SYM_W       = 8;
   localparam int LEN_W       = 9;
   localparam int ASZ_W       = 3;
   localparam int NUM_SYMBOLS = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic OP_LOAD_B    = 1'b0;
   localparam logic OP_STREAM_A  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_3      = 3'd4;

   localparam logic [ASZ_W-1:0] RST_ALPHABET_SIZE = 3'd4;
   localparam logic [SYM_W-1:0] RST_SYMBOL_0      = 8'd65;
   localparam logic [SYM_W-1:0] RST_SYMBOL_1      = 8'd67;
   localparam logic [SYM_W-1:0] RST_SYMBOL_2      = 8'd71;
   localparam logic [SYM_W-1:0] RST_SYMBOL_3      = 8'd84;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_PASS  = 5'b00100,
      S_FETCH = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

endpackage

[hw/rtl/lcs_channels.sv]
// Channel interfaces: the character request channel and the length response channel.
interface lcs_req_if import lcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, output opcode, output symbol, output last, input ready);
   modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

interface lcs_rsp_if import lcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] lcs_length;
   logic             too_long;

   modport source (output valid, output lcs_length, output too_long, input ready);
   modport sink   (input valid, input lcs_length, input too_long, output ready);
endinterface

[hw/rtl/lcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lcs_length_row_wise.sv]
// Top level of the row-wise longest-common-subsequence length engine.
//
//   Channel   Direction  Beat contents                     Handshake
//   req_bus   in         opcode, symbol, last              valid/ready
//   rsp_bus   out        lcs_length, too_long              valid/ready
//   csr_*     in         csr_index, csr_wdata              csr_we, no wait
//
// A B character is taken while idle and never produces a response.
// An A character whose symbol is in use starts a row pass over a non-empty B: the
// row pass issues one column per cycle through a three-deep read/compare/write
// pipeline on the row memory. A last A character then goes through a fetch and
// an emit state for the result and then a clearing sweep over the columns touched
// since the last one.
// After reset the row memory is swept over all MAX_B columns before the first beat.
// A response waiting on rsp_bus stalls only the next result, not request beats.
module lcs_length_row_wise import lcs_pkg::*; #(
   parameter int MAX_B    = 256,
   parameter int ALPHABET = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   lcs_req_if.sink               req_bus,
   lcs_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // PW holds a column number 0..MAX_B, AW addresses columns 1..MAX_B as 0..MAX_B-1.
   localparam int PW = $clog2(MAX_B + 1);
   localparam int AW = (MAX_B > 1) ? $clog2(MAX_B) : 1;
   localparam int MW = ALPHABET * PW;
   localparam int KW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

   state_type        state_ff, state_in;

   // Configuration registers.
   logic [ASZ_W-1:0] alph_ff;
   logic [SYM_W-1:0] sym_ff [NUM_SYMBOLS];

   // String B bookkeeping.
   logic [PW-1:0]    last_match_ff [ALPHABET];
   logic [PW-1:0]    blen_ff;
   logic             overflow_ff;
   logic             bclosed_ff;

   // Row pass and clearing control.
   logic [PW-1:0]    dirty_ff;
   logic [PW-1:0]    clr_ff;
   logic [PW-1:0]    j_ff;
   logic [KW-1:0]    idx_ff;
   logic             alast_ff;
   logic             s1_valid_ff;
   logic [PW-1:0]    s1_j_ff;
   logic             s2_valid_ff;
   logic [PW-1:0]    s2_j_ff;
   logic [PW-1:0]    s2_p_ff;

   // Response output register.
   logic             rsp_valid_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_too_ff;

   logic             req_fire;
   logic [ASZ_W-1:0] used;
   logic [PW-1:0]    eff_blen;
   logic             b_full;
   logic [PW-1:0]    lm_base [ALPHABET];
   logic [PW-1:0]    lm_new  [ALPHABET];
   logic             a_found;
   logic [KW-1:0]    a_idx;

   logic             mram_we;
   logic [MW-1:0]    mram_wdata;
   logic [MW-1:0]    mram_rdata;
   logic [PW-1:0]    p_raw;

   logic             issue;
   logic [PW-1:0]    b_val;
   logic [PW-1:0]    cand;
   logic             upd;
   logic             prow_we;
   logic [AW-1:0]    prow_waddr;
   logic [PW-1:0]    prow_wdata;
   logic [AW-1:0]    prow_raddr_a;
   logic [PW-1:0]    prow_rdata_a;
   logic [PW-1:0]    prow_rdata_b;
   logic             rsp_load;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Symbols in use, with sizes above the built alphabet acting as the full alphabet.
   assign used = (alph_ff > ASZ_W'(ALPHABET)) ? ASZ_W'(ALPHABET) : alph_ff;

   // A B beat after a closed string starts a fresh B.
   assign eff_blen = bclosed_ff ? '0 : blen_ff;
   assign b_full   = (eff_blen >= PW'(MAX_B));

   always_comb begin
      for (int k = 0; k < ALPHABET; k++) begin
         lm_base[k] = bclosed_ff ? '0 : last_match_ff[k];
         if ((ASZ_W'(k) < used) && (sym_ff[k] == req_bus.symbol)) begin
            lm_new[k] = eff_blen + PW'(1);
         end else begin
            lm_new[k] = lm_base[k];
         end
         mram_wdata[k*PW +: PW] = lm_new[k];
      end
   end

   // The lowest matching symbol index wins when codes repeat.
   always_comb begin
      a_found = 1'b0;
      a_idx   = '0;
      for (int k = ALPHABET - 1; k >= 0; k--) begin
         if ((ASZ_W'(k) < used) && (sym_ff[k] == req_bus.symbol)) begin
            a_found = 1'b1;
            a_idx   = KW'(k);
         end
      end
   end

   assign mram_we = req_fire && (req_bus.opcode == OP_LOAD_B) && !b_full;

   // The match table holds one row per column, one field per symbol.
   lcs_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_B)
   ) u_match_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (eff_blen[AW-1:0]),
      .wr_data (mram_wdata),
      .rd_addr (AW'(j_ff - PW'(1))),
      .rd_data (mram_rdata)
   );

   // Row pass pipeline: stage 0 reads the match entry of column j, stage 1 reads
   // the row at j and at p-1, stage 2 writes max(row[j], row[p-1] + 1) back.
   // Columns go from high to low, so the reads at p-1 and j-1 never see a write
   // of the same pass.
   assign issue = (state_ff == S_PASS) && (j_ff != '0);
   assign p_raw = mram_rdata[idx_ff*PW +: PW];

   assign b_val = (s2_p_ff == PW'(1)) ? '0 : prow_rdata_b;
   assign cand  = b_val + PW'(1);
   assign upd   = s2_valid_ff && (s2_p_ff != '0) && (cand > prow_rdata_a);

   assign prow_we      = upd || (state_ff == S_CLEAR && dirty_ff != '0);
   assign prow_waddr   = (state_ff == S_CLEAR) ? clr_ff[AW-1:0] : AW'(s2_j_ff - PW'(1));
   assign prow_wdata   = (state_ff == S_CLEAR) ? '0 : cand;
   assign prow_raddr_a = (state_ff == S_PASS) ? AW'(s1_j_ff - PW'(1))
                                              : AW'(blen_ff - PW'(1));

   // Two copies of the row give the two read addresses a column needs.
   lcs_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_B)
   ) u_row_ram_a (
      .clock   (clock),
      .wr_en   (prow_we),
      .wr_addr (prow_waddr),
      .wr_data (prow_wdata),
      .rd_addr (prow_raddr_a),
      .rd_data (prow_rdata_a)
   );

   lcs_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_B)
   ) u_row_ram_b (
      .clock   (clock),
      .wr_en   (prow_we),
      .wr_addr (prow_waddr),
      .wr_data (prow_wdata),
      .rd_addr (AW'(p_raw - PW'(2))),
      .rd_data (prow_rdata_b)
   );

   assign rsp_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (dirty_ff == '0 || clr_ff == dirty_ff - PW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire && req_bus.opcode == OP_STREAM_A) begin
               if (a_found && blen_ff != '0) begin
                  state_in = S_PASS;
               end else if (req_bus.last) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_PASS: begin
            if (j_ff == '0 && !s1_valid_ff && !s2_valid_ff) begin
               state_in = alast_ff ? S_FETCH : S_IDLE;
            end
         end
         S_FETCH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_CLEAR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         alph_ff      <= RST_ALPHABET_SIZE;
         sym_ff[0]    <= RST_SYMBOL_0;
         sym_ff[1]    <= RST_SYMBOL_1;
         sym_ff[2]    <= RST_SYMBOL_2;
         sym_ff[3]    <= RST_SYMBOL_3;
         for (int k = 0; k < ALPHABET; k++) begin
            last_match_ff[k] <= '0;
         end
         blen_ff      <= '0;
         overflow_ff  <= 1'b0;
         bclosed_ff   <= 1'b0;
         dirty_ff     <= PW'(MAX_B);
         clr_ff       <= '0;
         j_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;

         if (csr_we) begin
            unique case (csr_index)
               CSR_ALPHABET_SIZE: alph_ff   <= csr_wdata[ASZ_W-1:0];
               CSR_SYMBOL_0:      sym_ff[0] <= csr_wdata;
               CSR_SYMBOL_1:      sym_ff[1] <= csr_wdata;
               CSR_SYMBOL_2:      sym_ff[2] <= csr_wdata;
               CSR_SYMBOL_3:      sym_ff[3] <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (req_fire && req_bus.opcode == OP_LOAD_B) begin
            bclosed_ff <= req_bus.last;
            if (b_full) begin
               overflow_ff <= 1'b1;
               blen_ff     <= eff_blen;
               for (int k = 0; k < ALPHABET; k++) begin
                  last_match_ff[k] <= lm_base[k];
               end
            end else begin
               if (bclosed_ff) begin
                  overflow_ff <= 1'b0;
               end
               blen_ff <= eff_blen + PW'(1);
               for (int k = 0; k < ALPHABET; k++) begin
                  last_match_ff[k] <= lm_new[k];
               end
            end
         end

         if (state_ff == S_IDLE && state_in == S_PASS) begin
            j_ff <= blen_ff;
            if (blen_ff > dirty_ff) begin
               dirty_ff <= blen_ff;
            end
         end else if (issue) begin
            j_ff <= j_ff - PW'(1);
         end

         if (state_ff == S_CLEAR) begin
            if (state_in == S_IDLE) begin
               clr_ff   <= '0;
               dirty_ff <= '0;
            end else begin
               clr_ff <= clr_ff + PW'(1);
            end
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire && req_bus.opcode == OP_STREAM_A) begin
         idx_ff   <= a_idx;
         alast_ff <= req_bus.last;
      end
      s1_j_ff <= j_ff;
      s2_j_ff <= s1_j_ff;
      s2_p_ff <= p_raw;
      if (rsp_load) begin
         rsp_len_ff <= (blen_ff == '0) ? '0 : LEN_W'(prow_rdata_a);
         rsp_too_ff <= overflow_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.lcs_length = rsp_len_ff;
   assign rsp_bus.too_long   = rsp_too_ff;

endmodule
